### rtl/core/cfcd_pkg.sv
// Shared types, constants and the CRC-32 byte step for the control frame deframer.
// No dependencies.
package cfcd_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] HDR_FIRST  = 8'h05;
  localparam logic [7:0] HDR_SECOND = 8'h0A;
  localparam logic [7:0] FTR_FIRST  = 8'h50;
  localparam logic [7:0] FTR_SECOND = 8'hA0;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Body byte positions after the two header bytes.
  localparam logic [3:0] POS_SETTING   = 4'd0;
  localparam logic [3:0] POS_VALUE_HI  = 4'd1;
  localparam logic [3:0] POS_VALUE_LO  = 4'd2;
  localparam logic [3:0] POS_CRC_B3    = 4'd3;
  localparam logic [3:0] POS_CRC_B2    = 4'd4;
  localparam logic [3:0] POS_CRC_B1    = 4'd5;
  localparam logic [3:0] POS_CRC_B0    = 4'd6;
  localparam logic [3:0] POS_FTR_FIRST = 4'd7;
  localparam logic [3:0] POS_FTR_LAST  = 4'd8;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HDR,
    PH_BODY
  } phase_t;

  // One body byte tagged with its position, as queued between front and back.
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] pos;
  } body_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    r = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/cfcd_if.sv
// Channel interfaces: received byte stream in, decoded frame results out.
// Depends on nothing.
interface cfcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfcd_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  setting_code;
  logic [15:0] setting_value;

  modport source (output valid, output setting_code, output setting_value, input ready);
  modport sink (input valid, input setting_code, input setting_value, output ready);
endinterface

### rtl/core/cfcd_front.sv
// Front end: header hunt and body byte tagging, one byte per cycle while the queue is not full.
// Depends on cfcd_pkg and cfcd_rx_if.
module cfcd_front (
  input  logic                  clk,
  input  logic                  rst,
  cfcd_rx_if.sink               rx,
  input  cfcd_pkg::fifo_status_t status,
  output logic                  push,
  output cfcd_pkg::body_word_t  word
);
  import cfcd_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] idx, idx_next;
  logic       accept;

  assign rx.ready = !status.full;
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    if (accept) begin
      case (phase)
        PH_HDR: begin
          idx_next = 4'd0;
          if (rx.rx_byte == HDR_SECOND) begin
            phase_next = PH_BODY;
          end else if (rx.rx_byte == HDR_FIRST) begin
            phase_next = PH_HDR;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (idx == POS_FTR_LAST) begin
            phase_next = PH_HUNT;
            idx_next   = 4'd0;
          end else begin
            idx_next = idx + 4'd1;
          end
        end
        default: begin
          idx_next   = 4'd0;
          phase_next = (rx.rx_byte == HDR_FIRST) ? PH_HDR : PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    push      = 1'b0;
    word.data = rx.rx_byte;
    word.pos  = idx;
    case (phase)
      PH_BODY: push = accept;
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      idx   <= 4'd0;
    end else begin
      phase <= phase_next;
      idx   <= idx_next;
    end
  end

  a_idx_zero_outside_body: assert property (@(posedge clk) disable iff (rst)
    phase != PH_BODY |-> idx == 4'd0)
    else $error("front: position counter nonzero outside body");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    idx <= POS_FTR_LAST)
    else $error("front: position counter beyond footer");

endmodule

### rtl/core/cfcd_fifo.sv
// Short queue of tagged body bytes between front and back.
// Depends on cfcd_pkg.
module cfcd_fifo #(
  parameter int DEPTH = cfcd_pkg::FIFO_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  cfcd_pkg::body_word_t   wr_word,
  input  logic                   pop,
  output cfcd_pkg::body_word_t   rd_word,
  output cfcd_pkg::fifo_status_t status
);
  import cfcd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  body_word_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign rd_word      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full && !pop))
    else $error("fifo: push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("fifo: pop from empty queue");

endmodule

### rtl/core/cfcd_back.sv
// Back end: CRC accumulation, field capture, footer/CRC check, result register.
// Depends on cfcd_pkg and cfcd_res_if.
module cfcd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  cfcd_pkg::body_word_t   word,
  input  cfcd_pkg::fifo_status_t status,
  output logic                   pop,
  cfcd_res_if.source             res
);
  import cfcd_pkg::*;

  logic [31:0] crc_accum;
  logic [7:0]  held_setting;
  logic [15:0] held_value;
  logic [31:0] held_crc;
  logic [7:0]  footer_first;
  logic        res_valid;
  logic [7:0]  res_code;
  logic [15:0] res_value;
  logic        frame_ok;

  assign pop      = !status.empty && (!res_valid || res.ready);
  assign frame_ok = (footer_first == FTR_FIRST) && (word.data == FTR_SECOND) &&
                    (held_crc == ~crc_accum);

  assign res.valid         = res_valid;
  assign res.setting_code  = res_code;
  assign res.setting_value = res_value;

  always_ff @(posedge clk) begin
    if (pop) begin
      case (word.pos)
        POS_SETTING: begin
          held_setting <= word.data;
          crc_accum    <= crc_byte(CRC_INIT, word.data);
        end
        POS_VALUE_HI: begin
          held_value[15:8] <= word.data;
          crc_accum        <= crc_byte(crc_accum, word.data);
        end
        POS_VALUE_LO: begin
          held_value[7:0] <= word.data;
          crc_accum       <= crc_byte(crc_accum, word.data);
        end
        POS_CRC_B3, POS_CRC_B2, POS_CRC_B1, POS_CRC_B0: begin
          held_crc <= {held_crc[23:0], word.data};
        end
        POS_FTR_FIRST: begin
          footer_first <= word.data;
        end
        POS_FTR_LAST: begin
          res_code  <= held_setting;
          res_value <= held_value;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && word.pos == POS_FTR_LAST && frame_ok) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  a_result_only_on_last: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pop) && $past(word.pos) == POS_FTR_LAST)
    else $error("back: result raised without a footer byte");

  a_no_pop_when_stalled: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.ready |-> !pop)
    else $error("back: queue popped while result is stalled");

endmodule

### rtl/core/control_frame_crc32_deframer_top.sv
// Top level of the control frame deframer with CRC-32 check.
// Depends on cfcd_pkg, cfcd_if, cfcd_front, cfcd_fifo and cfcd_back.
//
// Usage:
//   rx  : valid/ready channel of received serial bytes, one word per byte.
//   res : valid/ready channel of decoded frames (setting_code, setting_value).
//   A frame is 05 0A, setting, value hi, value lo, CRC (4 bytes, big-endian),
//   50 A0. The CRC is reflected CRC-32 (init and final xor all ones) over the
//   setting and value bytes. Only frames whose footer and CRC both match give
//   a result; anything else is dropped silently and the header hunt resumes.
// Throughput: one byte per cycle while the result is not stalled. The front
//   end classifies each byte in the cycle it is taken; the back end takes one
//   byte per cycle (one eight-step CRC update sits in that path).
// Result: the final footer byte is written into the queue when taken; the back
//   end pops it into the result register once any bytes queued ahead of it
//   have been popped.
// Stall: the result register holds while res.ready is low; body bytes then
//   collect in the FIFO_DEPTH-entry queue and rx.ready drops once it is full.
// Reset: rst (synchronous, active high) empties the queue, clears the result
//   valid and puts the front end into the header hunt.
module control_frame_crc32_deframer_top #(
  parameter int FIFO_DEPTH = cfcd_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  cfcd_rx_if.sink    rx,
  cfcd_res_if.source res
);
  import cfcd_pkg::*;

  body_word_t   push_word;
  body_word_t   pop_word;
  fifo_status_t q_status;
  logic         push;
  logic         pop;

  // Front: hunts for the header, tags body bytes with their position.
  cfcd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .status (q_status),
    .push   (push),
    .word   (push_word)
  );

  // Queue decouples byte intake from the checking side.
  cfcd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_word (push_word),
    .pop     (pop),
    .rd_word (pop_word),
    .status  (q_status)
  );

  // Back: CRC, field capture, footer/CRC check, result register.
  cfcd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .word   (pop_word),
    .status (q_status),
    .pop    (pop),
    .res    (res)
  );

endmodule
